>>> rtl/core/vne_pkg.sv
// vne_pkg: shared types and constants of the voxel neighbor enumerator.
// Used by vne_ctrl, vne_dp, voxel_neighbor_enumerator, vne_checker and tb; no dependencies.
package vne_pkg;

    localparam int VNE_COORD_BITS = 10;
    localparam int ID_W           = 30;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIM_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORTHOGONAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THREE_D    = 3'd4;

    // per-axis offset codes: step -1, 0, +1
    localparam logic [1:0] OFF_NEG  = 2'd0;
    localparam logic [1:0] OFF_ZERO = 2'd1;
    localparam logic [1:0] OFF_POS  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_PLANE,
        ST_MUL_VOL,
        ST_CHECK,
        ST_DIV_K,
        ST_ROW_INIT,
        ST_DIV_J,
        ST_WALK_INIT,
        ST_WALK,
        ST_FINISH
    } vne_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_id;
        logic mul_plane;
        logic mul_vol;
        logic div_init_plane;
        logic div_init_row;
        logic div_step;
        logic walk_init;
        logic walk_step;
        logic finish;
    } vne_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_of_range;
        logic div_done;
        logic walk_end;
        logic cand;
        logic pend;
        logic can_push;
    } vne_sts_t;

endpackage

>>> rtl/core/vne_ctrl.sv
// vne_ctrl: sequencing state machine of the voxel neighbor enumerator.
// Depends on vne_pkg; drives vne_dp through vne_cmd_t, reads vne_sts_t.
module vne_ctrl import vne_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  vne_sts_t sts,
    output vne_cmd_t cmd
);

    vne_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MUL_PLANE;
            end
            ST_MUL_PLANE: state_next = ST_MUL_VOL;
            ST_MUL_VOL:   state_next = ST_CHECK;
            ST_CHECK: begin
                if (sts.out_of_range) state_next = ST_FINISH;
                else state_next = ST_DIV_K;
            end
            ST_DIV_K: begin
                if (sts.div_done) state_next = ST_ROW_INIT;
            end
            ST_ROW_INIT: state_next = ST_DIV_J;
            ST_DIV_J: begin
                if (sts.div_done) state_next = ST_WALK_INIT;
            end
            ST_WALK_INIT: state_next = ST_WALK;
            ST_WALK: begin
                // hold while a second hit would overwrite an unsent one
                if (!(sts.cand && sts.pend && !sts.can_push) && sts.walk_end) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.can_push) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_id = s_valid;
            end
            ST_MUL_PLANE: cmd.mul_plane = 1'b1;
            ST_MUL_VOL:   cmd.mul_vol   = 1'b1;
            ST_CHECK:     cmd.div_init_plane = !sts.out_of_range;
            ST_DIV_K:     cmd.div_step = 1'b1;
            ST_ROW_INIT:  cmd.div_init_row = 1'b1;
            ST_DIV_J:     cmd.div_step = 1'b1;
            ST_WALK_INIT: cmd.walk_init = 1'b1;
            ST_WALK:      cmd.walk_step = !(sts.cand && sts.pend && !sts.can_push);
            ST_FINISH:    cmd.finish = sts.can_push;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/vne_dp.sv
// vne_dp: datapath of the voxel neighbor enumerator: config registers, multipliers,
// shared restoring divider, offset walker and output register. Depends on vne_pkg.
module vne_dp import vne_pkg::*; #(
    parameter int COORD_BITS = VNE_COORD_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [ID_W-1:0]       s_voxel_id,
    input  vne_cmd_t              cmd,
    output vne_sts_t              sts,
    input  logic                  m_ready,
    output logic                  m_valid,
    output logic [ID_W-1:0]       m_neighbor_id,
    output logic                  m_found,
    output logic                  m_last
);

    // QB: coordinate / quotient bits, CDW: clamped dimension bits
    localparam int QB  = (COORD_BITS < 11) ? COORD_BITS : 11;
    localparam int CDW = (COORD_BITS < 11) ? COORD_BITS + 1 : 11;
    localparam int PW  = 2 * CDW;
    localparam int VW  = (3 * CDW > ID_W) ? 3 * CDW : ID_W;
    localparam int W   = (PW + QB > ID_W) ? PW + QB : ID_W;
    localparam int CW  = (QB > 1) ? $clog2(QB) : 1;
    localparam logic [17:0] DIM_LIM = 18'(1) << COORD_BITS;

    function automatic logic [CDW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] d);
        logic [17:0] de;
        de = 18'(d);
        if (de == 18'd0) return CDW'(1);
        else if (de > DIM_LIM) return CDW'(DIM_LIM);
        else return CDW'(de);
    endfunction

    logic [CFG_DATA_W-1:0] dim_x_reg, dim_y_reg, dim_z_reg;
    logic                  orth_reg, three_d_reg;

    logic [CDW-1:0] dxc, dyc, dzc;
    logic [ID_W-1:0] id_reg;
    logic [PW-1:0]   plane_reg;
    logic [VW-1:0]   vol_reg;

    logic [W-1:0]    rem_reg, dsh_reg;
    logic [QB-1:0]   quo_reg;
    logic [CW-1:0]   cnt_reg;
    logic [QB-1:0]   ci_reg, cj_reg, ck_reg;

    logic [1:0]      ox_reg, oy_reg, oz_reg;
    logic            pend_reg;
    logic [ID_W-1:0] pend_id_reg;

    logic            out_valid_reg;
    logic [ID_W-1:0] out_id_reg;
    logic            out_found_reg, out_last_reg;

    logic            rem_ge;
    logic            inb_x, inb_y, inb_z;
    logic [1:0]      nz;
    logic            cand;
    logic [ID_W-1:0] tx, ty, tz, nbr_id;
    logic            can_push;

    // ---- configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_x_reg   <= CFG_DATA_W'(1);
            dim_y_reg   <= CFG_DATA_W'(1);
            dim_z_reg   <= CFG_DATA_W'(1);
            orth_reg    <= 1'b0;
            three_d_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DIM_X:      dim_x_reg   <= cfg_data;
                REG_DIM_Y:      dim_y_reg   <= cfg_data;
                REG_DIM_Z:      dim_z_reg   <= cfg_data;
                REG_ORTHOGONAL: orth_reg    <= cfg_data[0];
                REG_THREE_D:    three_d_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        dxc = clamp_dim(dim_x_reg);
        dyc = clamp_dim(dim_y_reg);
        dzc = clamp_dim(dim_z_reg);
    end

    // ---- sizes and divider
    assign rem_ge = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_id)   id_reg    <= s_voxel_id;
        if (cmd.mul_plane) plane_reg <= PW'(dxc) * PW'(dyc);
        if (cmd.mul_vol)   vol_reg   <= VW'(plane_reg) * VW'(dzc);
        if (cmd.div_init_plane) begin
            rem_reg <= W'(id_reg);
            dsh_reg <= W'(plane_reg) << (QB - 1);
            quo_reg <= '0;
            cnt_reg <= CW'(QB - 1);
        end else if (cmd.div_init_row) begin
            ck_reg  <= quo_reg;
            dsh_reg <= W'(dxc) << (QB - 1);
            quo_reg <= '0;
            cnt_reg <= CW'(QB - 1);
        end else if (cmd.div_step) begin
            if (rem_ge) rem_reg <= rem_reg - dsh_reg;
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QB-2:0], rem_ge};
            cnt_reg <= cnt_reg - CW'(1);
        end
        if (cmd.walk_init) begin
            cj_reg <= quo_reg;
            ci_reg <= QB'(rem_reg);
        end
    end

    // ---- offset walk
    always_comb begin
        inb_x = !((ox_reg == OFF_NEG && ci_reg == '0) ||
                  (ox_reg == OFF_POS && CDW'(ci_reg) == dxc - CDW'(1)));
        inb_y = !((oy_reg == OFF_NEG && cj_reg == '0) ||
                  (oy_reg == OFF_POS && CDW'(cj_reg) == dyc - CDW'(1)));
        inb_z = !((oz_reg == OFF_NEG && ck_reg == '0) ||
                  (oz_reg == OFF_POS && CDW'(ck_reg) == dzc - CDW'(1)));
        nz = 2'((ox_reg != OFF_ZERO)) + 2'((oy_reg != OFF_ZERO)) + 2'((oz_reg != OFF_ZERO));
        cand = inb_x && inb_y && inb_z && (nz != 2'd0) && (!orth_reg || nz == 2'd1);

        // neighbor id = centre + dx_off + dy_off*dim_x + dz_off*plane, mod 2^30
        case (ox_reg)
            OFF_NEG: tx = '1;
            OFF_POS: tx = ID_W'(1);
            default: tx = '0;
        endcase
        case (oy_reg)
            OFF_NEG: ty = ID_W'(0) - ID_W'(dxc);
            OFF_POS: ty = ID_W'(dxc);
            default: ty = '0;
        endcase
        case (oz_reg)
            OFF_NEG: tz = ID_W'(0) - ID_W'(plane_reg);
            OFF_POS: tz = ID_W'(plane_reg);
            default: tz = '0;
        endcase
        nbr_id = id_reg + tx + ty + tz;
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk_init) begin
            ox_reg <= OFF_NEG;
            oy_reg <= OFF_NEG;
            oz_reg <= three_d_reg ? OFF_NEG : OFF_ZERO;
        end else if (cmd.walk_step) begin
            if (ox_reg == OFF_POS) begin
                ox_reg <= OFF_NEG;
                if (oy_reg == OFF_POS) begin
                    oy_reg <= OFF_NEG;
                    oz_reg <= oz_reg + 2'd1;
                end else begin
                    oy_reg <= oy_reg + 2'd1;
                end
            end else begin
                ox_reg <= ox_reg + 2'd1;
            end
        end
        if (cmd.walk_step && cand) pend_id_reg <= nbr_id;
    end

    // one hit is held back so the final one can carry last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (cmd.load_id) begin
            pend_reg <= 1'b0;
        end else if (cmd.walk_step && cand) begin
            pend_reg <= 1'b1;
        end
    end

    // ---- output register
    assign can_push = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((cmd.walk_step && cand && pend_reg) || cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk_step && cand && pend_reg) begin
            out_id_reg    <= pend_id_reg;
            out_found_reg <= 1'b1;
            out_last_reg  <= 1'b0;
        end else if (cmd.finish) begin
            out_id_reg    <= pend_reg ? pend_id_reg : '0;
            out_found_reg <= pend_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_neighbor_id = out_id_reg;
    assign m_found       = out_found_reg;
    assign m_last        = out_last_reg;

    always_comb begin
        sts.out_of_range = (VW'(id_reg) >= vol_reg);
        sts.div_done     = (cnt_reg == '0);
        sts.walk_end     = (ox_reg == OFF_POS) && (oy_reg == OFF_POS) &&
                           (oz_reg == OFF_POS || !three_d_reg);
        sts.cand         = cand;
        sts.pend         = pend_reg;
        sts.can_push     = can_push;
    end

endmodule

>>> rtl/core/voxel_neighbor_enumerator.sv
// voxel_neighbor_enumerator: top level, joins controller and datapath.
// Depends on vne_pkg, vne_ctrl and vne_dp.
//
//  channel | ports                                      | dir | beat
//  --------+--------------------------------------------+-----+-------------------------
//  s_      | s_valid s_ready s_voxel_id                 | in  | one centre voxel id
//  m_      | m_valid m_ready m_neighbor_id m_found m_last | out | one neighbor, last marked
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data     | in  | one register write
//
// Per input beat: two multiplies, a range check, two divisions (plane, then dim_x)
// on the shared one-bit-per-cycle divider, a one-offset-per-cycle walk over 27
// offsets (3D) or 9 (2D) and a final beat; out-of-range ids skip to the final beat.
// A new centre beat is taken only while idle. Result stalls on m_ready hold the
// walker only when a second hit meets a full output register. Reset (aresetn,
// synchronous, active low) restores the register defaults; no clearing pass.
// cfg_ready is always high; writes are expected only while the block is idle.
module voxel_neighbor_enumerator import vne_pkg::*; #(
    parameter int COORD_BITS = VNE_COORD_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // centre voxel beats
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ID_W-1:0]       s_voxel_id,
    // neighbor beats
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ID_W-1:0]       m_neighbor_id,
    output logic                  m_found,
    output logic                  m_last,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    vne_cmd_t cmd;
    vne_sts_t sts;

    // registers take a write every cycle
    assign cfg_ready = 1'b1;

    vne_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    vne_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_voxel_id    (s_voxel_id),
        .cmd           (cmd),
        .sts           (sts),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_neighbor_id (m_neighbor_id),
        .m_found       (m_found),
        .m_last        (m_last)
    );

endmodule

>>> verif/vne_checker.sv
`timescale 1ns / 100ps
// vne_checker: watches the centre, neighbor and register channels of the voxel
// neighbor enumerator, predicts every neighbor beat and compares in order.
// Depends on vne_pkg.
module vne_checker import vne_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [ID_W-1:0]       s_voxel_id,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [ID_W-1:0]       m_neighbor_id,
    input  logic                  m_found,
    input  logic                  m_last,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  end_of_run,
    output int                    fail_count,
    output int                    pending
);

    typedef struct {
        logic [ID_W-1:0] neighbor_id;
        logic            found;
        logic            last;
    } neighbor_beat_t;

    localparam int MAX_EXTENT = 1 << VNE_COORD_BITS;

    logic [CFG_DATA_W-1:0] grid_x, grid_y, grid_z;
    logic                  face_only, walk_3d;
    neighbor_beat_t        expected_beats[$];
    neighbor_beat_t        got, want;

    // dimension register as the grid sees it: 0 acts as 1, clipped to 2^COORD_BITS
    function automatic int extent(input logic [CFG_DATA_W-1:0] d);
        if (d == '0) return 1;
        if (int'(d) > MAX_EXTENT) return MAX_EXTENT;
        return int'(d);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] neighbor check: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic void predict_neighbors(input logic [ID_W-1:0] voxel);
        int             ex, ey, ez, cx, cy, cz, px, py, pz, ox, oy, oz;
        int             span, hits, reach, n;
        longint         plane, vid;
        neighbor_beat_t hit_list[27];
        neighbor_beat_t none;
        ex = extent(grid_x);
        ey = extent(grid_y);
        ez = extent(grid_z);
        plane = longint'(ex) * ey;
        vid = longint'(voxel);
        none.neighbor_id = '0;
        none.found = 1'b0;
        none.last = 1'b1;
        if (vid >= plane * ez) begin
            expected_beats.push_back(none);
            return;
        end
        cx = int'(vid % ex);
        cy = int'((vid / ex) % ey);
        cz = int'(vid / plane);
        span = walk_3d ? 27 : 9;
        hits = 0;
        // offsets walk dx fastest, then dy, then dz
        for (n = 0; n < span; n++) begin
            ox = n % 3 - 1;
            oy = (n % 9) / 3 - 1;
            oz = walk_3d ? n / 9 - 1 : 0;
            px = cx + ox;
            py = cy + oy;
            pz = cz + oz;
            reach = (ox < 0 ? -ox : ox) + (oy < 0 ? -oy : oy) + (oz < 0 ? -oz : oz);
            if (px < 0 || px >= ex || py < 0 || py >= ey || pz < 0 || pz >= ez) continue;
            if (reach == 0) continue;
            if (face_only && reach != 1) continue;
            hit_list[hits].neighbor_id = ID_W'(longint'(pz) * plane + longint'(py) * ex + px);
            hit_list[hits].found = 1'b1;
            hit_list[hits].last = 1'b0;
            hits++;
        end
        if (hits == 0) begin
            expected_beats.push_back(none);
            return;
        end
        hit_list[hits-1].last = 1'b1;
        for (n = 0; n < hits; n++) expected_beats.push_back(hit_list[n]);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            grid_x = 1;
            grid_y = 1;
            grid_z = 1;
            face_only = 1'b0;
            walk_3d = 1'b1;
            expected_beats.delete();
            fail_count = 0;
        end else begin
            // results leave before this edge's centre beat is queued
            if (m_valid && m_ready) begin
                got.neighbor_id = m_neighbor_id;
                got.found = m_found;
                got.last = m_last;
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("stray beat id=%0d found=%b last=%b",
                                              got.neighbor_id, got.found, got.last));
                end else begin
                    want = expected_beats.pop_front();
                    if (got.neighbor_id !== want.neighbor_id)
                        report_mismatch($sformatf("neighbor_id %0d, want %0d",
                                                  got.neighbor_id, want.neighbor_id));
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found %b, want %b (id %0d)",
                                                  got.found, want.found, want.neighbor_id));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b (id %0d)",
                                                  got.last, want.last, want.neighbor_id));
                end
            end
            if (s_valid && s_ready) predict_neighbors(s_voxel_id);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DIM_X:      grid_x = cfg_data;
                    REG_DIM_Y:      grid_y = cfg_data;
                    REG_DIM_Z:      grid_z = cfg_data;
                    REG_ORTHOGONAL: face_only = cfg_data[0];
                    REG_THREE_D:    walk_3d = cfg_data[0];
                    default: ;
                endcase
            end
            if (end_of_run && expected_beats.size() != 0)
                report_mismatch($sformatf("%0d neighbor beats never arrived",
                                          expected_beats.size()));
        end
        pending = expected_beats.size();
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for voxel_neighbor_enumerator; the checking lives
// in vne_checker. Depends on vne_pkg, vne_checker and the block's RTL.
module tb;
    import vne_pkg::*;

    // register indexes past the last defined one; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
    localparam logic [CFG_DATA_W-1:0] DATA_ALL_ONES  = '1;
    localparam int MAX_EXTENT      = 1 << VNE_COORD_BITS;
    localparam int SETTLE_CYCLES   = 64;       // settling time after every predicted beat is out
    localparam int RAND_PHASES     = 12;
    localparam int ITEMS_PER_PHASE = 26;
    localparam int CYCLE_LIMIT     = 900_000;  // watchdog bound on the whole run
    localparam logic [ID_W-1:0] ID_ALL_ONES = '1;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [ID_W-1:0]       s_voxel_id;
    logic                  m_valid;
    logic                  m_ready;
    logic [ID_W-1:0]       m_neighbor_id;
    logic                  m_found;
    logic                  m_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  end_of_run;
    int                    fail_count;
    int                    pending;

    // pacing switches, flipped per phase by the stimulus
    logic   sender_idles = 1'b1;
    logic   rx_idles     = 1'b1;
    longint grid_volume  = 1;
    int     cycle_count  = 0;
    int     phase, n;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    voxel_neighbor_enumerator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_voxel_id    (s_voxel_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_neighbor_id (m_neighbor_id),
        .m_found       (m_found),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    vne_checker neighbor_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_voxel_id    (s_voxel_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_neighbor_id (m_neighbor_id),
        .m_found       (m_found),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .end_of_run    (end_of_run),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: m_ready drops in bursts while rx_idles is set
    initial begin : result_sink
        int hold;
        hold = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else if (rx_idles && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 12) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // effective extent of a dimension register (0 acts as 1, clipped at the top)
    function automatic longint extent(input logic [CFG_DATA_W-1:0] d);
        if (d == '0) return 1;
        if (int'(d) > MAX_EXTENT) return MAX_EXTENT;
        return longint'(d);
    endfunction

    // Each beat task is entered and left at a falling edge; valid stays high
    // on exit so back-to-back beats never lower and raise it in one step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // full register set; optionally a write to an unused index goes first
    task automatic set_grid(input logic [CFG_DATA_W-1:0] gx, input logic [CFG_DATA_W-1:0] gy,
                            input logic [CFG_DATA_W-1:0] gz, input logic face,
                            input logic three, input logic spare);
        if (spare)
            cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                      CFG_DATA_W'($urandom));
        cfg_write(REG_DIM_X, gx);
        cfg_write(REG_DIM_Y, gy);
        cfg_write(REG_DIM_Z, gz);
        cfg_write(REG_ORTHOGONAL, {{(CFG_DATA_W-1){1'b0}}, face});
        cfg_write(REG_THREE_D, {{(CFG_DATA_W-1){1'b0}}, three});
        cfg_valid <= 1'b0;
        grid_volume = extent(gx) * extent(gy) * extent(gz);
    endtask

    task automatic send_voxel(input logic [ID_W-1:0] id);
        s_valid    <= 1'b1;
        s_voxel_id <= id;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // hold the sender until every predicted beat is out, then let the block settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // sender pacing after a beat: now and then a full drain, else a short gap
    task automatic pace_sender();
        if (sender_idles && $urandom_range(0, 39) == 0) begin
            wait_idle();
        end else if (sender_idles && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    endtask

    // mostly in-range centres; the rest sit on or past the volume edge, or anywhere
    function automatic logic [ID_W-1:0] pick_voxel();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return ID_W'($urandom_range(0, int'(grid_volume - 1)));
        if (roll < 78) return ID_W'(grid_volume - 1);
        if (roll < 84) return ID_W'(grid_volume);
        if (roll < 88) return '0;
        if (roll < 95) return ID_W'($urandom);
        return ID_W'(grid_volume + $urandom_range(1, 64));
    endfunction

    // small grids keep every centre near an edge; a few take any register value
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        if ($urandom_range(0, 9) == 0) return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(1, 9));
    endfunction

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_voxel_id = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        end_of_run = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // --- directed part ---
        // reset grid is a single voxel: no neighbor, then ids past the volume
        send_voxel('0);
        pace_sender();
        send_voxel(30'd1);
        pace_sender();
        send_voxel(ID_ALL_ONES);
        wait_idle();

        // 4x3x5, full cube: corners, centre, another inner voxel, one past the end
        set_grid(11'd4, 11'd3, 11'd5, 1'b0, 1'b1, 1'b0);
        send_voxel(30'd0);
        pace_sender();
        send_voxel(30'd59);
        pace_sender();
        send_voxel(30'd29);
        pace_sender();
        send_voxel(30'd60);
        pace_sender();
        send_voxel(30'd17);
        wait_idle();

        // face neighbors in the centre's own plane
        set_grid(11'd4, 11'd3, 11'd5, 1'b1, 1'b0, 1'b0);
        send_voxel(30'd0);
        pace_sender();
        send_voxel(30'd29);
        pace_sender();
        send_voxel(30'd59);
        pace_sender();
        send_voxel(30'd5);
        wait_idle();

        // face neighbors in 3D
        set_grid(11'd4, 11'd3, 11'd5, 1'b1, 1'b1, 1'b0);
        send_voxel(30'd29);
        pace_sender();
        send_voxel(30'd0);
        wait_idle();

        // largest grid: the volume covers the whole id range
        set_grid(11'd1024, 11'd1024, 11'd1024, 1'b0, 1'b1, 1'b0);
        send_voxel(ID_ALL_ONES);
        pace_sender();
        send_voxel('0);
        pace_sender();
        send_voxel(30'h2008_0200);
        pace_sender();
        send_voxel(30'h2AAA_AAAA);
        pace_sender();
        send_voxel(30'h1555_5555);
        wait_idle();

        // register extremes: x of 0 acts as 1, y of all ones clips; unused
        // indexes take all-ones, zero and random data and must change nothing
        cfg_write(REG_SPARE_FIRST, DATA_ALL_ONES);
        cfg_write(REG_SPARE_FIRST + 3'd1, '0);
        cfg_write(REG_SPARE_LAST, CFG_DATA_W'($urandom));
        set_grid('0, DATA_ALL_ONES, 11'd2, 1'b0, 1'b0, 1'b0);
        send_voxel(30'd0);
        pace_sender();
        send_voxel(30'd1023);
        pace_sender();
        send_voxel(30'd2047);
        pace_sender();
        send_voxel(30'd2048);
        wait_idle();

        // a single column: two face neighbors, then one
        set_grid(11'd1, 11'd1, 11'd3, 1'b1, 1'b1, 1'b0);
        send_voxel(30'd1);
        pace_sender();
        send_voxel(30'd0);
        wait_idle();

        // --- random part: a new grid per phase, idle-free final phase ---
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase == RAND_PHASES - 1) begin
                sender_idles = 1'b0;
                rx_idles = 1'b0;
            end else begin
                sender_idles = ($urandom_range(0, 3) != 0);
                rx_idles = ($urandom_range(0, 3) != 0);
            end
            set_grid(pick_dim(), pick_dim(), pick_dim(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_voxel(pick_voxel());
                pace_sender();
            end
            wait_idle();
        end

        // anything still queued in the checker is reported on this beat
        end_of_run <= 1'b1;
        @(negedge aclk);
        end_of_run <= 1'b0;
        @(negedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/vne_pkg.sv
rtl/core/vne_ctrl.sv
rtl/core/vne_dp.sv
rtl/core/voxel_neighbor_enumerator.sv
verif/vne_checker.sv
verif/tb.sv
